// File: sv/kprx_pkg.sv
// ----------------------------------------------------------------------------
// kprx_pkg
// Shared types and constants of the Kermit receive packet deframer.
// ----------------------------------------------------------------------------
package kprx_pkg;

    localparam logic [7:0] MARK_BYTE     = 8'h01;
    localparam logic [7:0] END_BYTE      = 8'h0D;
    localparam logic [7:0] CHAR_OFFSET   = 8'd32;
    localparam logic [7:0] MIN_LEN       = 8'd3;
    localparam logic [6:0] MAX_LEN_RESET = 7'd94;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_TOO_LONG  = 3'd1;
    localparam logic [2:0] CAUSE_TOO_SHORT = 3'd2;
    localparam logic [2:0] CAUSE_END_DATA  = 3'd3;
    localparam logic [2:0] CAUSE_BAD_END   = 3'd4;

    typedef enum logic [2:0] {
        PH_MARK  = 3'd0,
        PH_LEN   = 3'd1,
        PH_SEQ   = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5,
        PH_END   = 3'd6,
        PH_ERROR = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] check_value;
        logic [6:0] content_length;
        logic [7:0] pkt_type;
        logic [7:0] seq_number;
        logic [6:0] byte_index;
        logic [7:0] data_byte;
        logic [2:0] error_cause;
        logic [1:0] kind;
    } t_result;

endpackage

// File: sv/kermit_rx_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// kermit_rx_packet_deframer_top
// Kermit normal packet deframer for a received byte stream.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result word, held in the input register
// and then in the result register; a new byte can be taken every clock while
// the output is not stalled, a rate set by the single-pass phase update between
// the two registers. Bytes before a mark are reported as kind none; an error is
// sticky until reset. Write max_length only while idle.
module kermit_rx_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [2:0] error_cause, [10:3] data_byte,
                                        // [17:11] byte_index, [25:18] seq_number,
                                        // [33:26] pkt_type,
                                        // [40:34] content_length,
                                        // [48:41] check_value, [55:49] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // [6:0] max_length
);
    import kprx_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [6:0] r_max_length;
    logic       w_out_free;
    logic       w_step;
    t_result    w_result;
    t_result    w_out;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_step        = r_in_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_max_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    kprx_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (r_in_byte),
        .i_max_length (r_max_length),
        .o_result     (w_result)
    );

    kprx_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_in_valid),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out)
    );

    assign m_axis_tuser = w_out.kind;
    assign m_axis_tdata = {7'd0, w_out.check_value, w_out.content_length,
                           w_out.pkt_type, w_out.seq_number, w_out.byte_index,
                           w_out.data_byte, w_out.error_cause};

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && m_axis_tvalid))
        else $error("input stalled while a stage is empty");

    a_cause_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((w_out.kind == KIND_ERROR) == (w_out.error_cause != CAUSE_NONE)))
        else $error("error cause does not match result kind");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_out.kind == KIND_DATA)) |->
            (w_out.byte_index < w_out.content_length))
        else $error("content byte index beyond content length");

endmodule

// File: sv/kprx_fsm.sv
// ----------------------------------------------------------------------------
// kprx_fsm
// Packet phase tracker: one byte per step, builds the result word for it.
// ----------------------------------------------------------------------------
module kprx_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [6:0]       i_max_length,
    output kprx_pkg::t_result o_result
);
    import kprx_pkg::*;

    t_phase     r_phase, n_phase;
    logic [6:0] r_remaining, n_remaining;
    logic [6:0] r_total, n_total;
    logic [7:0] r_seq, n_seq;
    logic [7:0] r_type, n_type;
    logic [7:0] r_check, n_check;
    logic [7:0] w_decoded;
    logic [7:0] w_len_m3;

    assign w_decoded = i_byte - CHAR_OFFSET;
    assign w_len_m3  = w_decoded - MIN_LEN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MARK;
            r_remaining <= '0;
            r_total     <= '0;
            r_seq       <= '0;
            r_type      <= '0;
            r_check     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_total     <= n_total;
            r_seq       <= n_seq;
            r_type      <= n_type;
            r_check     <= n_check;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_total     = r_total;
        n_seq       = r_seq;
        n_type      = r_type;
        n_check     = r_check;
        o_result    = '0;
        case (r_phase)
            PH_MARK: begin
                if (i_byte == MARK_BYTE) n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (w_decoded > {1'b0, i_max_length}) begin
                    n_phase              = PH_ERROR;
                    o_result.kind        = KIND_ERROR;
                    o_result.error_cause = CAUSE_TOO_LONG;
                end else if (w_decoded < MIN_LEN) begin
                    n_phase              = PH_ERROR;
                    o_result.kind        = KIND_ERROR;
                    o_result.error_cause = CAUSE_TOO_SHORT;
                end else begin
                    n_total     = w_len_m3[6:0];
                    n_remaining = w_len_m3[6:0];
                    n_phase     = PH_SEQ;
                end
            end
            PH_SEQ: begin
                n_seq   = w_decoded;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_phase = (r_remaining != '0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                if (i_byte == END_BYTE) begin
                    n_phase              = PH_ERROR;
                    o_result.kind        = KIND_ERROR;
                    o_result.error_cause = CAUSE_END_DATA;
                end else begin
                    o_result.kind           = KIND_DATA;
                    o_result.data_byte      = i_byte;
                    o_result.byte_index     = r_total - r_remaining;
                    o_result.seq_number     = r_seq;
                    o_result.pkt_type       = r_type;
                    o_result.content_length = r_total;
                    n_remaining             = r_remaining - 7'd1;
                    if (r_remaining == 7'd1) n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_check = w_decoded;
                n_phase = PH_END;
            end
            PH_END: begin
                if (i_byte != END_BYTE) begin
                    n_phase              = PH_ERROR;
                    o_result.kind        = KIND_ERROR;
                    o_result.error_cause = CAUSE_BAD_END;
                end else begin
                    o_result.kind           = KIND_DONE;
                    o_result.seq_number     = r_seq;
                    o_result.pkt_type       = r_type;
                    o_result.content_length = r_total;
                    o_result.check_value    = r_check;
                    n_phase                 = PH_MARK;
                end
            end
            default: begin
                n_phase              = PH_ERROR;
                o_result.kind        = KIND_ERROR;
                o_result.error_cause = CAUSE_BAD_END;
            end
        endcase
    end

endmodule

// File: sv/kprx_out_reg.sv
// ----------------------------------------------------------------------------
// kprx_out_reg
// Result register on the master side; loads when empty or being drained.
// ----------------------------------------------------------------------------
module kprx_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kprx_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output kprx_pkg::t_result o_result
);
    import kprx_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: tb/kprx_deframe_checker.sv
// ----------------------------------------------------------------------------
// kprx_deframe_checker
// Watches the byte, result and max_length channels of the Kermit deframer,
// keeps its own copy of the framing state, and compares every result word
// field by field with the one predicted for the byte that caused it.
// ----------------------------------------------------------------------------
module kprx_deframe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kprx_pkg::*;

    t_phase     frm_phase;
    logic [6:0] len_limit;
    logic [6:0] bytes_left;
    logic [6:0] body_len;
    logic [7:0] seq_val;
    logic [7:0] type_char;
    logic [7:0] check_val;

    t_result    expected_words[$];
    t_result    next_word;
    t_result    want;

    task automatic raise_error(input logic [2:0] cause, inout t_result r);
        frm_phase     = PH_ERROR;
        r.kind        = KIND_ERROR;
        r.error_cause = cause;
    endtask

    task automatic deframe_byte(input logic [7:0] c, output t_result r);
        logic [7:0] len;
        r = '0;
        case (frm_phase)
            PH_MARK: begin
                if (c == MARK_BYTE) frm_phase = PH_LEN;
            end
            PH_LEN: begin
                len = c - CHAR_OFFSET;
                if (len > {1'b0, len_limit}) begin
                    raise_error(CAUSE_TOO_LONG, r);
                end else if (len < MIN_LEN) begin
                    raise_error(CAUSE_TOO_SHORT, r);
                end else begin
                    body_len   = 7'(len - MIN_LEN);
                    bytes_left = body_len;
                    frm_phase  = PH_SEQ;
                end
            end
            PH_SEQ: begin
                seq_val   = c - CHAR_OFFSET;
                frm_phase = PH_TYPE;
            end
            PH_TYPE: begin
                type_char = c;
                frm_phase = (bytes_left != 0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                if (c == END_BYTE) begin
                    raise_error(CAUSE_END_DATA, r);
                end else begin
                    r.kind           = KIND_DATA;
                    r.data_byte      = c;
                    r.byte_index     = body_len - bytes_left;
                    r.seq_number     = seq_val;
                    r.pkt_type       = type_char;
                    r.content_length = body_len;
                    bytes_left       = bytes_left - 7'd1;
                    if (bytes_left == 0) frm_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                check_val = c - CHAR_OFFSET;
                frm_phase = PH_END;
            end
            PH_END: begin
                if (c != END_BYTE) begin
                    raise_error(CAUSE_BAD_END, r);
                end else begin
                    r.kind           = KIND_DONE;
                    r.seq_number     = seq_val;
                    r.pkt_type       = type_char;
                    r.content_length = body_len;
                    r.check_value    = check_val;
                    frm_phase        = PH_MARK;
                end
            end
            default: begin
                raise_error(CAUSE_BAD_END, r);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frm_phase    = PH_MARK;
            len_limit    = MAX_LEN_RESET;
            bytes_left   = '0;
            body_len     = '0;
            seq_val      = '0;
            type_char    = '0;
            check_val    = '0;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) len_limit = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                deframe_byte(i_s_tdata, next_word);
                expected_words.push_back(next_word);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("result word 0x%0h/%0h with no byte waiting",
                           i_m_tuser, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("error_cause", want.error_cause, i_m_tdata[2:0]);
                    check_field("data_byte", want.data_byte, i_m_tdata[10:3]);
                    check_field("byte_index", want.byte_index, i_m_tdata[17:11]);
                    check_field("seq_number", want.seq_number, i_m_tdata[25:18]);
                    check_field("pkt_type", want.pkt_type, i_m_tdata[33:26]);
                    check_field("content_length", want.content_length, i_m_tdata[40:34]);
                    check_field("check_value", want.check_value, i_m_tdata[48:41]);
                    check_field("tdata padding", 0, i_m_tdata[55:49]);
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// File: tb/tb_kermit_rx_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_kermit_rx_packet_deframer_top
// Feeds the deframer well-formed Kermit packets with random contents and
// line noise under several max_length settings, with random gaps and a long
// output stall, then closes with one randomly chosen error and its sticky
// aftermath. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_kermit_rx_packet_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kprx_pkg::*;

    typedef enum {TAIL_GOOD, TAIL_CR_MID, TAIL_CR_LAST, TAIL_BAD_END} t_tail;
    typedef enum {END_TOO_LONG, END_TOO_SHORT, END_CR_MID, END_CR_LAST,
                  END_BAD_TAIL} t_ending;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;     // [2:0] error_cause .. [48:41] check_value
    logic [1:0]  m_axis_tuser;     // [1:0] kind
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;       // [6:0] max_length

    int          fail_count;
    int          pending;
    int          bytes_sent;
    int          packets_sent;
    int          limit_writes;
    int          largest_body;
    int          words_seen;
    logic [6:0]  cur_limit;
    bit          burst;

    kermit_rx_packet_deframer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    kprx_deframe_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) words_seen <= words_seen + 1;
    end

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic push_byte(input logic [7:0] b);
        int gap;
        int r;
        gap = 0;
        if (!burst) begin
            r = $urandom_range(0, 99);
            if (r >= 94) gap = $urandom_range(8, 30);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = b;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input int nc, input logic [7:0] seq_c,
                               input logic [7:0] type_c, input logic [7:0] check_c,
                               input t_tail tail);
        int         cr_at;
        logic [7:0] b;
        cr_at = -1;
        if (tail == TAIL_CR_MID) cr_at = $urandom_range(0, nc - 2);
        if (tail == TAIL_CR_LAST) cr_at = nc - 1;
        push_byte(MARK_BYTE);
        push_byte(8'(nc) + MIN_LEN + CHAR_OFFSET);
        push_byte(seq_c);
        push_byte(type_c);
        for (int i = 0; i < nc; i++) begin
            if (i == cr_at) begin
                b = END_BYTE;
            end else if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    2: b = MARK_BYTE;
                    default: b = CHAR_OFFSET;
                endcase
            end else begin
                do b = 8'($urandom); while (b == END_BYTE);
            end
            push_byte(b);
        end
        push_byte(check_c);
        if (tail == TAIL_BAD_END) begin
            do b = 8'($urandom); while (b == END_BYTE);
        end else begin
            b = END_BYTE;
        end
        push_byte(b);
        packets_sent++;
        if (nc > largest_body) largest_body = nc;
    endtask

    function automatic int pick_body_len();
        int max_nc;
        int r;
        max_nc = int'(cur_limit) - 3;
        r = $urandom_range(0, 99);
        if (r < 5) return max_nc;
        if (r < 15) return $urandom_range(0, max_nc);
        return $urandom_range(0, (max_nc < 6) ? max_nc : 6);
    endfunction

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [6:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_limit   = v;
        limit_writes++;
    endtask

    // receiver: random back-pressure, one long hold-off early in the run
    initial begin
        int r;
        bit squeezed;
        squeezed      = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!squeezed && words_seen >= 60) begin
                m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                squeezed = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                m_axis_tready = 1'b1;
                repeat (100) @(negedge i_clk);
            end else if (r < 62) begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end else if (r < 93) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d result words outstanding", pending);
        $display("kermit_rx_packet_deframer_top verification failed");
        $finish;
    end

    initial begin
        t_ending    ending;
        int         budget;
        logic [7:0] c;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        bytes_sent    = 0;
        packets_sent  = 0;
        limit_writes  = 0;
        largest_body  = 0;
        words_seen    = 0;
        cur_limit     = MAX_LEN_RESET;
        burst         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(END_BYTE);
        send_packet(0, 8'h00, 8'hFF, 8'h00, TAIL_GOOD);
        send_packet(1, 8'hFF, 8'h00, 8'hFF, TAIL_GOOD);
        send_packet(2, CHAR_OFFSET, 8'h59, 8'h7E, TAIL_GOOD);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: write_limit(7'd127);
                    2: write_limit(7'(MIN_LEN));
                    5: write_limit(MAX_LEN_RESET);
                    default: write_limit(7'($urandom_range(3, 127)));
                endcase
            end
            burst  = ($urandom_range(0, 3) == 0);
            budget = bytes_sent + ((p == 0) ? 130 : 120);
            while (bytes_sent < budget) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        do c = 8'($urandom); while (c == MARK_BYTE);
                        push_byte(c);
                    end
                end
                send_packet(pick_body_len(), 8'($urandom), 8'($urandom), 8'($urandom),
                            TAIL_GOOD);
            end
        end

        // close with one error; everything after it stays an error
        wait_idle();
        burst  = 1'b0;
        ending = t_ending'($urandom_range(0, 4));
        case (ending)
            END_TOO_LONG: begin
                if ($urandom_range(0, 1) == 1) write_limit('0);
                do c = 8'($urandom); while (8'(c - CHAR_OFFSET) <= {1'b0, cur_limit});
                push_byte(MARK_BYTE);
                push_byte(c);
            end
            END_TOO_SHORT: begin
                if ($urandom_range(0, 1) == 1) write_limit('0);
                c = CHAR_OFFSET + 8'($urandom_range(0, (cur_limit < 2) ? cur_limit : 2));
                push_byte(MARK_BYTE);
                push_byte(c);
            end
            END_CR_MID: begin
                send_packet($urandom_range(2, 8), 8'($urandom), 8'($urandom),
                            8'($urandom), TAIL_CR_MID);
            end
            END_CR_LAST: begin
                send_packet($urandom_range(1, 8), 8'($urandom), 8'($urandom),
                            8'($urandom), TAIL_CR_LAST);
            end
            default: begin
                send_packet($urandom_range(0, 8), 8'($urandom), 8'($urandom),
                            8'($urandom), TAIL_BAD_END);
            end
        endcase
        repeat (20) push_byte(8'($urandom));
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge i_clk);

        $display("%0d bytes in %0d packets (largest %0d content bytes), %0d result words",
                 bytes_sent, packets_sent, largest_body, words_seen);
        $display("%0d max_length writes; closing error case %s", limit_writes, ending.name());
        if (fail_count == 0) begin
            $display("kermit_rx_packet_deframer_top verification clean");
        end else begin
            $display("kermit_rx_packet_deframer_top verification failed");
        end
        $finish;
    end

endmodule
